FILE: hdl/bts_pkg.sv
`default_nettype none
package bts_pkg;

   localparam int MaxWidthDefault  = 256;
   localparam int MaxHeightDefault = 256;
   localparam int AddrBits         = 16;
   localparam int ChanBits         = 16;
   localparam int CsrDataBits      = 9;
   localparam int CsrIndexBits     = 1;

   localparam logic CmdWrite  = 1'b0;
   localparam logic CmdSample = 1'b1;

   localparam logic [CsrIndexBits-1:0] CsrImageWidth  = 1'b0;
   localparam logic [CsrIndexBits-1:0] CsrImageHeight = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [15:0] texel_index;
      logic [15:0] texel_red;
      logic [15:0] texel_green;
      logic [15:0] texel_blue;
      logic signed [31:0] u_coord;
      logic signed [31:0] v_coord;
   } req_type;

   typedef struct packed {
      logic [15:0] sample_red;
      logic [15:0] sample_green;
      logic [15:0] sample_blue;
   } rsp_type;

endpackage
`default_nettype wire

FILE: hdl/bts_ram.sv
`default_nettype none
module bts_ram #(
   parameter int Width = 16,
   parameter int Depth = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output      logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

FILE: hdl/bilinear_texture_sampler.sv
`default_nettype none
// Bilinear texture sampler. An item with cmd=write stores one 48-bit RGB
// texel at texel_index and gives no result. An item with cmd=sample blends
// the four texels around (u,v) and returns one rounded, saturated RGB result:
// u wraps, v clamps, columns wrap and rows clamp. One item per cycle is
// accepted while no result is held on rsp_. A result that is held on rsp_
// stalls the whole pipe, and the input with it. The pipe has six registers:
// coordinate scale, neighbor index, address multiply, texel read together
// with the weight products, texel times weight, and sum/round into the
// output register. The texel memory has four copies, which give four read
// ports. A write travels down the pipe and reaches all four copies at the
// edge where a sample in the same place would read. Every sample therefore
// sees exactly the writes accepted before it. The memory has no reset:
// reading a texel that was never written returns unspecified data. The user
// must write image_width and image_height through the csr_ port only while
// idle; the block itself does not enforce it.
module bilinear_texture_sampler
   import bts_pkg::*;
#(
   parameter int MaxWidth  = MaxWidthDefault,
   parameter int MaxHeight = MaxHeightDefault
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_ready,
   input  wire bts_pkg::req_type             req_data,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   output      bts_pkg::rsp_type             rsp_data,
   input  wire logic                         csr_write,
   input  wire logic [bts_pkg::CsrIndexBits-1:0] csr_index,
   input  wire logic [bts_pkg::CsrDataBits-1:0]  csr_data
);
   localparam int Wb = $clog2(MaxWidth + 1);
   localparam int Hb = $clog2(MaxHeight + 1);
   localparam int Cb = $clog2(MaxWidth);
   localparam int Rb = $clog2(MaxHeight);

   // pipeline advance: whole pipe stalls while result held
   logic adv;
   assign adv = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // config registers
   logic [8:0] width_ff, height_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'd256;
         height_ff <= 9'd256;
      end else if (csr_write) begin
         unique case (csr_index)
            CsrImageWidth:  width_ff  <= csr_data;
            CsrImageHeight: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // effective sizes: zero -> 1, above max -> max
   logic [Wb-1:0] w_eff;
   logic [Hb-1:0] h_eff;
   always_comb begin
      if (width_ff == 9'd0) w_eff = Wb'(1);
      else if (32'(width_ff) > MaxWidth) w_eff = Wb'(MaxWidth);
      else w_eff = Wb'(width_ff);
      if (height_ff == 9'd0) h_eff = Hb'(1);
      else if (32'(height_ff) > MaxHeight) h_eff = Hb'(MaxHeight);
      else h_eff = Hb'(height_ff);
   end

   // texel write path: carried down to the read stage, see stage 3
   logic [47:0] wr_word;
   assign wr_word = {req_data.texel_red, req_data.texel_green, req_data.texel_blue};

   // ---------------- stage 1: scale coordinates
   logic          s1_v_ff;
   logic          s1_wr_ff;
   logic [15:0]   s1_wa_ff;
   logic [47:0]   s1_wd_ff;
   logic [16+Wb:0] s1_tu_ff;
   logic [17+Hb:0] s1_tv_ff;
   logic [16:0]    vf;
   always_comb begin
      if (req_data.v_coord[31]) vf = 17'd0;
      else if (req_data.v_coord > 32'sd65536) vf = 17'h10000;
      else vf = req_data.v_coord[16:0];
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s1_wr_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff  <= req_valid && (req_data.cmd == CmdSample);
         s1_wr_ff <= req_valid && (req_data.cmd == CmdWrite);
      end
      if (adv) begin
         s1_tu_ff <= (17+Wb)'(req_data.u_coord[15:0]) * (17+Wb)'(w_eff)
                     + (17+Wb)'(32768);
         s1_tv_ff <= (18+Hb)'(vf) * (18+Hb)'(h_eff) + (18+Hb)'(32768);
         s1_wa_ff <= req_data.texel_index;
         s1_wd_ff <= wr_word;
      end
   end

   // ---------------- stage 2: neighbor indices
   // t>>16 is idx+1; idx = -1 only when t>>16 == 0
   logic [Wb:0] iu;
   logic [Hb+1:0] iv;
   assign iu = s1_tu_ff[16+Wb:16];
   assign iv = s1_tv_ff[17+Hb:16];
   logic [Cb-1:0] c0, c1;
   logic [Rb-1:0] r0, r1;
   always_comb begin
      logic [Wb:0] c0w, c1w;
      logic [Hb+1:0] hm1;
      c0w = (iu == '0) ? (Wb+1)'(w_eff) - 1'b1 : iu - 1'b1;
      c1w = c0w + 1'b1;
      if (c1w >= (Wb+1)'(w_eff)) c1w = '0;
      c0 = Cb'(c0w);
      c1 = Cb'(c1w);
      hm1 = (Hb+2)'(h_eff) - 1'b1;
      // r0 = clamp(iv-1), r1 = clamp(iv)
      if (iv == '0) r0 = '0;
      else if (iv - 1'b1 > hm1) r0 = Rb'(hm1);
      else r0 = Rb'(iv - 1'b1);
      if (iv > hm1) r1 = Rb'(hm1);
      else r1 = Rb'(iv);
   end
   logic          s2_v_ff;
   logic          s2_wr_ff;
   logic [15:0]   s2_wa_ff;
   logic [47:0]   s2_wd_ff;
   logic [Cb-1:0] s2_c0_ff, s2_c1_ff;
   logic [Rb-1:0] s2_r0_ff, s2_r1_ff;
   logic [15:0]   s2_fx_ff, s2_fy_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff  <= 1'b0;
         s2_wr_ff <= 1'b0;
      end else if (adv) begin
         s2_v_ff  <= s1_v_ff;
         s2_wr_ff <= s1_wr_ff;
      end
      if (adv) begin
         s2_c0_ff <= c0; s2_c1_ff <= c1;
         s2_r0_ff <= r0; s2_r1_ff <= r1;
         s2_fx_ff <= s1_tu_ff[15:0];
         s2_fy_ff <= s1_tv_ff[15:0];
         s2_wa_ff <= s1_wa_ff;
         s2_wd_ff <= s1_wd_ff;
      end
   end

   // ---------------- stage 3: row*width, final addresses
   // a write held here is stored as it leaves, in item order with the reads
   logic          s3_v_ff;
   logic          s3_wr_ff;
   logic [15:0]   s3_wa_ff;
   logic [47:0]   s3_wd_ff;
   logic [15:0]   s3_a_ff [4];
   logic [15:0]   s3_fx_ff, s3_fy_ff;
   logic [31:0]   rw0, rw1;
   assign rw0 = 32'(s2_r0_ff) * 32'(w_eff);
   assign rw1 = 32'(s2_r1_ff) * 32'(w_eff);
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff  <= 1'b0;
         s3_wr_ff <= 1'b0;
      end else if (adv) begin
         s3_v_ff  <= s2_v_ff;
         s3_wr_ff <= s2_wr_ff;
      end
      if (adv) begin
         s3_a_ff[0] <= 16'(rw0 + 32'(s2_c0_ff));
         s3_a_ff[1] <= 16'(rw0 + 32'(s2_c1_ff));
         s3_a_ff[2] <= 16'(rw1 + 32'(s2_c0_ff));
         s3_a_ff[3] <= 16'(rw1 + 32'(s2_c1_ff));
         s3_fx_ff <= s2_fx_ff;
         s3_fy_ff <= s2_fy_ff;
         s3_wa_ff <= s2_wa_ff;
         s3_wd_ff <= s2_wd_ff;
      end
   end

   logic wr_en;
   assign wr_en = s3_wr_ff && adv;

   // ---------------- stage 4: texel read (four memory copies), weights
   logic [47:0] tex [4];
   for (genvar k = 0; k < 4; k++) begin : g_bank
      bts_ram #(.Width(48), .Depth(1 << AddrBits)) u_ram (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (s3_wa_ff),
         .wr_data (s3_wd_ff),
         .rd_en   (adv),
         .rd_addr (s3_a_ff[k]),
         .rd_data (tex[k])
      );
   end
   logic        s4_v_ff;
   logic [32:0] s4_w_ff [4];
   logic [16:0] gx, gy;
   assign gx = 17'h10000 - 17'(s3_fx_ff);
   assign gy = 17'h10000 - 17'(s3_fy_ff);
   always_ff @(posedge clock) begin
      if (reset) s4_v_ff <= 1'b0;
      else if (adv) s4_v_ff <= s3_v_ff;
      if (adv) begin
         s4_w_ff[0] <= 33'(gx) * 33'(gy);
         s4_w_ff[1] <= 33'(s3_fx_ff) * 33'(gy);
         s4_w_ff[2] <= 33'(gx) * 33'(s3_fy_ff);
         s4_w_ff[3] <= 33'(s3_fx_ff) * 33'(s3_fy_ff);
      end
   end

   // ---------------- stage 5: texel * weight products
   // weights reach 2^32 only when the others are zero; split off that case
   logic        s5_v_ff;
   logic [47:0] s5_p_ff [4][3];
   always_ff @(posedge clock) begin
      if (reset) s5_v_ff <= 1'b0;
      else if (adv) s5_v_ff <= s4_v_ff;
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            for (int c = 0; c < 3; c++) begin
               if (s4_w_ff[k][32])
                  s5_p_ff[k][c] <= {tex[k][47-16*c -: 16], 32'd0};
               else
                  s5_p_ff[k][c] <= 48'(tex[k][47-16*c -: 16]) * 48'(s4_w_ff[k][31:0]);
            end
         end
      end
   end

   // ---------------- stage 6: sum, round, saturate -> output register
   rsp_type res;
   always_comb begin
      logic [49:0] s;
      logic [17:0] r;
      for (int c = 0; c < 3; c++) begin
         s = 50'(s5_p_ff[0][c]) + 50'(s5_p_ff[1][c]) + 50'(s5_p_ff[2][c])
             + 50'(s5_p_ff[3][c]) + 50'h80000000;
         r = s[49:32];
         res[47-16*c -: 16] = (r > 18'hFFFF) ? 16'hFFFF : r[15:0];
      end
   end
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (adv) rsp_valid <= s5_v_ff;
      if (adv) rsp_data <= res;
   end
endmodule
`default_nettype wire

FILE: hdl/bts_checker.sv
`default_nettype none
module bts_checker
   import bts_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped or changed while stalled");
   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while result held");
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result after reset");
endmodule

bind bilinear_texture_sampler bts_checker u_bts_checker (
   .clock, .reset, .req_ready,
   .rsp_valid, .rsp_ready, .rsp_data
);
`default_nettype wire

FILE: test/bilinear_texture_sampler_tb.sv
`timescale 1ns / 1ps
module bilinear_texture_sampler_tb;
   import bts_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int DrainCycles = 12;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [CsrIndexBits-1:0] csr_index = CsrImageWidth;
   logic [CsrDataBits-1:0] csr_data = '0;

   bilinear_texture_sampler u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // Local copy of the texture and of the size registers.
   logic [47:0] texture_copy [65536];
   logic [8:0] width_reg = 9'd256;
   logic [8:0] height_reg = 9'd256;
   rsp_type expected_colors [$];

   int send_idle_pct = 0;   // chance per cycle that the sender idles
   int stall_pct = 0;       // chance per cycle that the receiver stalls
   int hold_cycles = 0;     // long receiver hold-off, counted down below
   int mismatch_count = 0;
   int cycle_count = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Run limit: generous margin over the slowest legal run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Receiver: random stalls, plus the long hold-off when requested.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Result checker: every accepted result against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_colors.size() == 0) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
               $display("unexpected result %h", rsp_data);
         end else begin
            want = expected_colors.pop_front();
            if (rsp_data.sample_red !== want.sample_red ||
                rsp_data.sample_green !== want.sample_green ||
                rsp_data.sample_blue !== want.sample_blue) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("mismatch: expected r=%h g=%h b=%h, got r=%h g=%h b=%h",
                           want.sample_red, want.sample_green, want.sample_blue,
                           rsp_data.sample_red, rsp_data.sample_green,
                           rsp_data.sample_blue);
            end
         end
      end
   end

   function automatic int unsigned dim_in_use(logic [8:0] reg_value);
      if (reg_value == 0) return 1;
      if (reg_value > 256) return 256;
      return 32'(reg_value);
   endfunction

   function automatic int unsigned clamp_row(int r, int unsigned h);
      if (r < 0) return 0;
      if (r > int'(h) - 1) return h - 1;
      return r;
   endfunction

   // Bilinear blend of the four texels around (u,v).
   function automatic rsp_type bilinear_blend(logic signed [31:0] u, logic signed [31:0] v);
      int unsigned w, h, uf, vf, fx, fy, c0, c1, r0, r1;
      longint unsigned t, gx, gy, wt00, wt10, wt01, wt11, acc, rounded;
      int cu, cv;
      logic [15:0] a00, a10, a01, a11;
      logic [15:0] chan [3];
      rsp_type res;
      w = dim_in_use(width_reg);
      h = dim_in_use(height_reg);
      uf = 32'(u[15:0]);
      if (v[31]) vf = 0;
      else if (v > 65536) vf = 65536;
      else vf = v;
      t = longint'(uf) * w + 32768;
      cu = int'(t >> 16) - 1;
      fx = 32'(t & 64'hFFFF);
      t = longint'(vf) * h + 32768;
      cv = int'(t >> 16) - 1;
      fy = 32'(t & 64'hFFFF);
      c0 = (cu < 0) ? w - 1 : cu;
      c1 = c0 + 1;
      if (c1 >= w) c1 = 0;
      r0 = clamp_row(cv, h);
      r1 = clamp_row(cv + 1, h);
      a00 = 16'(r0 * w + c0);
      a10 = 16'(r0 * w + c1);
      a01 = 16'(r1 * w + c0);
      a11 = 16'(r1 * w + c1);
      gx = 65536 - fx;
      gy = 65536 - fy;
      wt00 = gx * gy;
      wt10 = fx * gy;
      wt01 = gx * fy;
      wt11 = longint'(fx) * fy;
      for (int ch = 0; ch < 3; ch++) begin
         acc = texture_copy[a00][47-16*ch -: 16] * wt00
             + texture_copy[a10][47-16*ch -: 16] * wt10
             + texture_copy[a01][47-16*ch -: 16] * wt01
             + texture_copy[a11][47-16*ch -: 16] * wt11;
         rounded = (acc + 64'h8000_0000) >> 32;
         chan[ch] = (rounded > 65535) ? 16'hFFFF : rounded[15:0];
      end
      res.sample_red = chan[0];
      res.sample_green = chan[1];
      res.sample_blue = chan[2];
      return res;
   endfunction

   // Sends one item; updates the texture copy or queues the expected color
   // at the edge where the item is accepted. Called at a clock edge.
   task automatic send_item(req_type item);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      if (item.cmd == CmdWrite)
         texture_copy[item.texel_index] = {item.texel_red, item.texel_green, item.texel_blue};
      else
         expected_colors.push_back(bilinear_blend(item.u_coord, item.v_coord));
   endtask

   function automatic logic [15:0] random_chan();
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic signed [31:0] random_v();
      case ($urandom_range(9))
         0: return $urandom;
         1: return -$urandom_range(1, 70000);
         2: return 65536 + $urandom_range(1, 70000);
         default: return $urandom_range(0, 65536);
      endcase
   endfunction

   function automatic req_type write_item(logic [15:0] index);
      req_type item;
      item.cmd = CmdWrite;
      item.texel_index = index;
      item.texel_red = random_chan();
      item.texel_green = random_chan();
      item.texel_blue = random_chan();
      item.u_coord = $urandom;   // ignored by a write
      item.v_coord = $urandom;
      return item;
   endfunction

   function automatic req_type sample_item(logic signed [31:0] u, logic signed [31:0] v);
      req_type item;
      item.cmd = CmdSample;
      item.texel_index = 16'($urandom);   // ignored by a sample
      item.texel_red = 16'($urandom);
      item.texel_green = 16'($urandom);
      item.texel_blue = 16'($urandom);
      item.u_coord = u;
      item.v_coord = v;
      return item;
   endfunction

   // Size registers change only when the block has drained.
   task automatic set_texture_size(logic [8:0] w, logic [8:0] h);
      req_valid <= 1'b0;
      while (expected_colors.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= CsrImageWidth;
      csr_data <= w;
      @(posedge clock);
      csr_index <= CsrImageHeight;
      csr_data <= h;
      @(posedge clock);
      csr_write <= 1'b0;
      width_reg = w;
      height_reg = h;
   endtask

   // Writes every texel a sample can reach at the current size.
   task automatic fill_texture();
      int unsigned n;
      n = dim_in_use(width_reg) * dim_in_use(height_reg);
      for (int unsigned i = 0; i < n; i++) send_item(write_item(16'(i)));
   endtask

   // Mixed traffic: mostly samples, some rewrites in and outside the texture.
   task automatic mixed_traffic(int count);
      int unsigned n;
      n = dim_in_use(width_reg) * dim_in_use(height_reg);
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(7))
            0: send_item(write_item(16'($urandom_range(n - 1))));
            1: send_item(write_item(16'($urandom)));
            default: send_item(sample_item($urandom, random_v()));
         endcase
      end
   endtask

   task automatic test_directed();
      // zero in both size registers means a 1x1 texture
      set_texture_size(9'd0, 9'd0);
      send_item(write_item(16'hFFFF));
      send_item(write_item(16'd0));
      send_item(sample_item(32'sh0000_0000, 32'sh0000_0000));
      send_item(sample_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
      send_item(sample_item(32'sh8000_0000, 32'sh8000_0000));
      set_texture_size(9'd2, 9'd2);
      fill_texture();
      send_item(sample_item(32'sh0000_0000, 32'sh0001_0000));
      send_item(sample_item(32'shFFFF_FFFF, 32'sh0001_0001));
      send_item(sample_item(32'sh0000_8000, 32'sh0000_8000));
      send_item(sample_item(32'sh0000_4000, 32'sh0000_4000));
      send_item(sample_item(32'sh0000_C000, -32'sd1));
      send_item(sample_item(32'sh1234_FFFF, 32'sh0000_FFFF));
      send_item(sample_item(32'shDEAD_0001, 32'sh0000_0001));
   endtask

   task automatic test_random();
      logic [8:0] w, h;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 86; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 86; end
            default: begin send_idle_pct = 14; stall_pct = 14; end
         endcase
         case (phase)
            0: begin w = 9'd256; h = 9'd1;   end   // widest row
            1: begin w = 9'd1;   h = 9'd511; end   // height saturates to 256
            2: begin w = 9'd511; h = 9'd0;   end   // width saturates, height zero
            default: begin
               w = 9'($urandom_range(1, 8));
               h = 9'($urandom_range(1, 8));
            end
         endcase
         set_texture_size(w, h);
         fill_texture();
         mixed_traffic(15);
      end
   endtask

   // Receiver holds off for a long stretch while samples keep coming, so the
   // pipeline fills and the input stalls.
   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct = 0;
      set_texture_size(9'd4, 9'd3);
      fill_texture();
      hold_cycles <= 300;
      for (int i = 0; i < 40; i++) send_item(sample_item($urandom, random_v()));
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      test_backpressure();
      req_valid <= 1'b0;
      while (expected_colors.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
